// File: rtl/core/bfps_pkg.sv
`timescale 1ns / 1ps

package bfps_pkg;

    localparam int FIELDS     = 34;
    localparam int VALUE_BITS = 32;

    localparam int FIELD_W = 6;
    localparam int ADDR_W  = $clog2(FIELDS);
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int OUT_W   = 32;
    localparam int POP_W   = 64;

    localparam logic [FIELD_W:0] FIELD_LIMIT = (FIELD_W + 1)'(FIELDS);
    localparam logic [ADDR_W-1:0] FALLBACK_BASE = ADDR_W'(FIELDS - 3);

    localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_HIT      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FALLBACK = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 2'd2;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd3;

    localparam logic [POP_W-1:0] POP_M1 = 64'h5555555555555555;
    localparam logic [POP_W-1:0] POP_M2 = 64'h3333333333333333;
    localparam logic [POP_W-1:0] POP_M4 = 64'h0f0f0f0f0f0f0f0f;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic signed [OUT_W-1:0]      t_out_value;

    function automatic t_value fit_value(input t_out_value wv);
        logic signed [63:0] w;
        w = 64'(wv);
        return w[VALUE_BITS-1:0];
    endfunction

    function automatic t_out_value out_value(input t_value v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/core/bfps_if.sv
`timescale 1ns / 1ps

interface bfps_req_if;
    logic                                valid;
    logic                                ready;
    logic [bfps_pkg::MODE_W-1:0]         mode;
    logic [bfps_pkg::FIELD_W-1:0]        field_index;
    logic signed [bfps_pkg::OUT_W-1:0]   write_value;

    modport source (output valid, output mode, output field_index, output write_value,
                    input ready);
    modport sink   (input valid, input mode, input field_index, input write_value,
                    output ready);
endinterface

interface bfps_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [bfps_pkg::STAT_W-1:0]         status;
    logic signed [bfps_pkg::OUT_W-1:0]   read_value;
    logic [bfps_pkg::FIELD_W-1:0]        slot_rank;

    modport source (output valid, output status, output read_value, output slot_rank,
                    input ready);
    modport sink   (input valid, input status, input read_value, input slot_rank,
                    output ready);
endinterface

// File: rtl/core/bfps_ram.sv
`timescale 1ns / 1ps

module bfps_ram #(
    parameter int DEPTH = 34,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bfps_rank.sv
`timescale 1ns / 1ps

module bfps_rank (
    input  logic [bfps_pkg::FIELDS-1:0]  i_mask,
    input  logic [bfps_pkg::ADDR_W-1:0]  i_field,
    output logic [bfps_pkg::FIELD_W-1:0] o_rank
);

    logic [bfps_pkg::FIELDS-1:0] below;
    logic [bfps_pkg::POP_W-1:0]  x0, x1, x2, x3, x4, x5, x6;

    // bits strictly below the addressed field
    always_comb begin
        for (int j = 0; j < bfps_pkg::FIELDS; j++) begin
            below[j] = i_mask[j] && (j < int'(i_field));
        end
    end

    // swar popcount, bytes summed by shifted adds
    always_comb begin
        x0 = bfps_pkg::POP_W'(below);
        x1 = x0 - ((x0 >> 1) & bfps_pkg::POP_M1);
        x2 = (x1 & bfps_pkg::POP_M2) + ((x1 >> 2) & bfps_pkg::POP_M2);
        x3 = (x2 + (x2 >> 4)) & bfps_pkg::POP_M4;
        x4 = x3 + (x3 >> 8);
        x5 = x4 + (x4 >> 16);
        x6 = x5 + (x5 >> 32);
    end

    assign o_rank = x6[bfps_pkg::FIELD_W-1:0];

endmodule

// File: rtl/core/bitmap_packed_field_store.sv
`timescale 1ns / 1ps

// channel  | dir | handshake     | payload
// i_req    | in  | valid / ready | mode, field_index, write_value
// o_rsp    | out | valid / ready | status, read_value, slot_rank
//
// one transaction in s1 at a time: accept cycle does rank, mask update and the
// value memory access; the output register takes the result when it is free.
// values are held per field in a one-port-read synchronous memory; the mask and
// popcount rank give the packed slot. synchronous active-low reset clears the mask
// and the valid flags; memory contents are undefined until written.
// a stalled o_rsp holds one finished result while one more transaction is taken.

module bitmap_packed_field_store (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfps_req_if.sink   i_req,
    bfps_rsp_if.source o_rsp
);

    logic [bfps_pkg::FIELDS-1:0] r_mask, n_mask;

    logic                          r_s1_valid;
    logic [bfps_pkg::STAT_W-1:0]   r_s1_status, n_s1_status;
    logic [bfps_pkg::FIELD_W-1:0]  r_s1_slot, n_s1_slot;
    logic                          r_s1_use_mem, n_s1_use_mem;
    bfps_pkg::t_out_value          r_s1_value, n_s1_value;

    logic                          r_out_valid;
    logic [bfps_pkg::STAT_W-1:0]   r_out_status;
    logic [bfps_pkg::FIELD_W-1:0]  r_out_slot;
    bfps_pkg::t_out_value          r_out_value;

    logic                          accept, s1_adv;
    logic                          field_ok, hit, fb_try, fb_hit;
    logic [bfps_pkg::ADDR_W-1:0]   addr, fb_addr, sel_addr;
    logic [bfps_pkg::FIELD_W-1:0]  rank;
    logic                          mem_we;
    bfps_pkg::t_value              wval, rdata;

    assign i_req.ready = !r_s1_valid;
    assign accept      = i_req.valid && !r_s1_valid;
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);

    assign field_ok = {1'b0, i_req.field_index} < bfps_pkg::FIELD_LIMIT;
    assign addr     = i_req.field_index[bfps_pkg::ADDR_W-1:0];
    assign fb_addr  = bfps_pkg::FALLBACK_BASE + bfps_pkg::ADDR_W'(i_req.field_index[1:0]);
    assign hit      = field_ok && r_mask[addr];
    assign fb_try   = field_ok && !hit && (i_req.mode != bfps_pkg::MODE_WRITE)
                      && (i_req.mode != bfps_pkg::MODE_REMOVE)
                      && (i_req.field_index < bfps_pkg::FIELD_W'(3));
    assign fb_hit   = fb_try && r_mask[fb_addr];
    assign sel_addr = fb_hit ? fb_addr : addr;
    assign wval     = bfps_pkg::fit_value(i_req.write_value);
    assign mem_we   = accept && field_ok && (i_req.mode == bfps_pkg::MODE_WRITE);

    bfps_rank u_rank (
        .i_mask  (r_mask),
        .i_field (sel_addr),
        .o_rank  (rank)
    );

    bfps_ram #(
        .DEPTH (bfps_pkg::FIELDS),
        .WIDTH (bfps_pkg::VALUE_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (addr),
        .i_wdata (wval),
        .i_re    (accept),
        .i_raddr (sel_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_mask       = r_mask;
        n_s1_status  = bfps_pkg::ST_ABSENT;
        n_s1_slot    = rank;
        n_s1_use_mem = 1'b0;
        n_s1_value   = '1;
        if (!field_ok) begin
            n_s1_status = bfps_pkg::ST_INVALID;
            n_s1_slot   = '0;
        end else begin
            case (i_req.mode)
                bfps_pkg::MODE_WRITE: begin
                    n_mask[addr] = 1'b1;
                    n_s1_status  = hit ? bfps_pkg::ST_HIT : bfps_pkg::ST_ABSENT;
                    n_s1_value   = bfps_pkg::out_value(wval);
                end
                bfps_pkg::MODE_REMOVE: begin
                    if (hit) begin
                        n_mask[addr] = 1'b0;
                        n_s1_status  = bfps_pkg::ST_HIT;
                        n_s1_use_mem = 1'b1;
                    end
                end
                default: begin
                    if (hit) begin
                        n_s1_status  = bfps_pkg::ST_HIT;
                        n_s1_use_mem = 1'b1;
                    end else if (fb_hit) begin
                        n_s1_status  = bfps_pkg::ST_FALLBACK;
                        n_s1_use_mem = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mask     <= n_mask;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status  <= n_s1_status;
            r_s1_slot    <= n_s1_slot;
            r_s1_use_mem <= n_s1_use_mem;
            r_s1_value   <= n_s1_value;
        end
        if (s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_slot   <= r_s1_slot;
            r_out_value  <= r_s1_use_mem ? bfps_pkg::out_value(rdata) : r_s1_value;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.slot_rank  = r_out_slot;

endmodule
